// ===== sv/nshp_pkg.sv =====
// Shared types, constants and helpers for the NSFE chunk header parser.
`default_nettype none

package nshp_pkg;

    localparam int unsigned MIN_FILE_LEN = 8;
    localparam int unsigned INFO_MIN_LEN = 9;

    localparam logic [31:0] ID_INFO = 32'h4F46_4E49;
    localparam logic [31:0] ID_NEND = 32'h444E_454E;

    localparam int unsigned HDR_BYTES  = 8;
    localparam int unsigned SEEN_W     = $clog2(MIN_FILE_LEN + 1);
    localparam int unsigned HDR_IDX_W  = $clog2(HDR_BYTES);
    localparam int unsigned PAY_IDX_W  = 4;

    // Payload positions of the INFO fields that are captured.
    localparam logic [PAY_IDX_W-1:0] POS_LOAD_LO = 4'd0;
    localparam logic [PAY_IDX_W-1:0] POS_LOAD_HI = 4'd1;
    localparam logic [PAY_IDX_W-1:0] POS_INIT_LO = 4'd2;
    localparam logic [PAY_IDX_W-1:0] POS_INIT_HI = 4'd3;
    localparam logic [PAY_IDX_W-1:0] POS_PLAY_LO = 4'd4;
    localparam logic [PAY_IDX_W-1:0] POS_PLAY_HI = 4'd5;
    localparam logic [PAY_IDX_W-1:0] POS_SONGS   = 4'd8;

    typedef enum logic [3:0] {
        PH_MAGIC   = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_DONE    = 4'b1000
    } t_phase;

    typedef struct packed {
        logic        long_enough;
        logic        magic_valid;
        logic [15:0] load_addr;
        logic [15:0] init_addr;
        logic [15:0] play_addr;
        logic [7:0]  num_songs;
    } t_result;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] v;
        unique case (idx)
            2'd0: v = 8'h4E;
            2'd1: v = 8'h53;
            2'd2: v = 8'h46;
            2'd3: v = 8'h45;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== sv/nshp_walker.sv =====
// Parser state and the per-byte update that walks magic, chunk headers and payloads.
`default_nettype none

module nshp_walker
    import nshp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output t_result         o_result
);

    logic [SEEN_W-1:0]          r_seen,    n_seen;
    t_phase                     r_phase,   n_phase;
    logic [HDR_IDX_W-1:0]       r_hdr_idx, n_hdr_idx;
    logic [8*(HDR_BYTES-1)-1:0] r_hdr,     n_hdr;
    logic [31:0]                r_skip,    n_skip;
    logic                       r_info,    n_info;
    logic [PAY_IDX_W-1:0]       r_pay_idx, n_pay_idx;
    logic                       r_magic,   n_magic;
    logic [15:0]                r_load,    n_load;
    logic [15:0]                r_init,    n_init;
    logic [15:0]                r_play,    n_play;
    logic [7:0]                 r_songs,   n_songs;

    logic [31:0] hdr_len;
    logic [31:0] hdr_id;
    logic        ok;

    // The eighth header byte is used straight from the input, so only seven are stored.
    assign hdr_len = r_hdr[31:0];
    assign hdr_id  = {i_byte, r_hdr[55:32]};

    always_comb begin
        n_seen    = r_seen;
        n_phase   = r_phase;
        n_hdr_idx = r_hdr_idx;
        n_hdr     = r_hdr;
        n_skip    = r_skip;
        n_info    = r_info;
        n_pay_idx = r_pay_idx;
        n_magic   = r_magic;
        n_load    = r_load;
        n_init    = r_init;
        n_play    = r_play;
        n_songs   = r_songs;

        if (r_seen < SEEN_W'(MIN_FILE_LEN)) begin
            n_seen = r_seen + SEEN_W'(1);
        end

        unique case (r_phase)
            PH_MAGIC: begin
                n_magic = ((r_hdr_idx == '0) || r_magic)
                          && (i_byte == magic_byte(r_hdr_idx[1:0]));
                if (r_hdr_idx == HDR_IDX_W'(3)) begin
                    n_hdr_idx = '0;
                    n_phase   = n_magic ? PH_HEADER : PH_DONE;
                end else begin
                    n_hdr_idx = r_hdr_idx + HDR_IDX_W'(1);
                end
            end
            PH_HEADER: begin
                if (r_hdr_idx == HDR_IDX_W'(HDR_BYTES - 1)) begin
                    // A header is only acted on when another byte follows it.
                    if (!i_last) begin
                        n_hdr_idx = '0;
                        n_pay_idx = '0;
                        n_info    = (hdr_id == ID_INFO) && (hdr_len >= 32'(INFO_MIN_LEN));
                        if (n_info) begin
                            n_load  = '0;
                            n_init  = '0;
                            n_play  = '0;
                            n_songs = '0;
                        end
                        if (hdr_id == ID_NEND) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_skip  = hdr_len;
                            n_phase = (hdr_len == '0) ? PH_HEADER : PH_PAYLOAD;
                        end
                    end
                end else begin
                    for (int k = 0; k < HDR_BYTES - 1; k++) begin
                        if (r_hdr_idx == HDR_IDX_W'(k)) begin
                            n_hdr[8*k +: 8] = i_byte;
                        end
                    end
                    n_hdr_idx = r_hdr_idx + HDR_IDX_W'(1);
                end
            end
            PH_PAYLOAD: begin
                if (r_skip == '0) begin
                    n_phase   = PH_HEADER;
                    n_hdr_idx = '0;
                end else begin
                    if (r_info) begin
                        unique case (r_pay_idx)
                            POS_LOAD_LO: n_load[7:0]  = i_byte;
                            POS_LOAD_HI: n_load[15:8] = i_byte;
                            POS_INIT_LO: n_init[7:0]  = i_byte;
                            POS_INIT_HI: n_init[15:8] = i_byte;
                            POS_PLAY_LO: n_play[7:0]  = i_byte;
                            POS_PLAY_HI: n_play[15:8] = i_byte;
                            POS_SONGS:   n_songs      = i_byte;
                            default: ;
                        endcase
                        if (r_pay_idx != '1) begin
                            n_pay_idx = r_pay_idx + PAY_IDX_W'(1);
                        end
                    end
                    n_skip = r_skip - 32'd1;
                    if (r_skip == 32'd1) begin
                        n_info    = 1'b0;
                        n_pay_idx = '0;
                        n_hdr_idx = '0;
                        n_phase   = PH_HEADER;
                    end
                end
            end
            PH_DONE: ;
            default: ;
        endcase

        ok = (n_seen == SEEN_W'(MIN_FILE_LEN));
        o_result.long_enough = ok;
        o_result.magic_valid = ok && n_magic;
        o_result.load_addr   = ok ? n_load  : '0;
        o_result.init_addr   = ok ? n_init  : '0;
        o_result.play_addr   = ok ? n_play  : '0;
        o_result.num_songs   = ok ? n_songs : '0;

        // The final byte of a file returns the walker to its reset state.
        if (i_last) begin
            n_seen    = '0;
            n_phase   = PH_MAGIC;
            n_hdr_idx = '0;
            n_skip    = '0;
            n_info    = 1'b0;
            n_pay_idx = '0;
            n_magic   = 1'b0;
            n_load    = '0;
            n_init    = '0;
            n_play    = '0;
            n_songs   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= '0;
            r_phase   <= PH_MAGIC;
            r_hdr_idx <= '0;
            r_skip    <= '0;
            r_info    <= 1'b0;
            r_pay_idx <= '0;
            r_magic   <= 1'b0;
            r_load    <= '0;
            r_init    <= '0;
            r_play    <= '0;
            r_songs   <= '0;
        end else if (i_step) begin
            r_seen    <= n_seen;
            r_phase   <= n_phase;
            r_hdr_idx <= n_hdr_idx;
            r_skip    <= n_skip;
            r_info    <= n_info;
            r_pay_idx <= n_pay_idx;
            r_magic   <= n_magic;
            r_load    <= n_load;
            r_init    <= n_init;
            r_play    <= n_play;
            r_songs   <= n_songs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_hdr <= n_hdr;
        end
    end

endmodule

`default_nettype wire

// ===== sv/nshp_out_stage.sv =====
// Result register that holds one parse result until the downstream side takes it.
`default_nettype none

module nshp_out_stage
    import nshp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    output logic         o_space,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_space  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

// ===== sv/nsfe_chunk_header_parser_top.sv =====
// Top level of the NSFE chunk header parser: input register, walker and result register.
`default_nettype none

// Takes an NSFE file one byte per word and, on the word flagged as the last byte, delivers one
// result: whether the file was at least eight bytes long, whether it opened with the NSFE magic,
// and the load, init and play addresses and song count of the last INFO chunk used. A byte is
// accepted every cycle unless the input stalls as below. Each byte is caught in an input
// register and then updates the parse state; a last byte also loads the result register when it
// updates the parse state, so o_out_valid rises once the last byte has moved from the input
// register into the result register. Input only stalls when a last byte waits in the input
// register while the previous result is still held in the result register and not being taken.
module nsfe_chunk_header_parser_top
    import nshp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_file_byte,
    input  wire logic        i_last_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_long_enough,
    output logic             o_magic_valid,
    output logic [15:0]      o_load_addr,
    output logic [15:0]      o_init_addr,
    output logic [15:0]      o_play_addr,
    output logic [7:0]       o_num_songs
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       step;
    logic       out_space;
    t_result    walk_result;
    t_result    out_result;

    // Ordinary bytes never wait; a last byte needs room in the result register.
    assign step       = r_in_valid && (!r_in_last || out_space);
    assign o_in_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_file_byte;
            r_in_last <= i_last_byte;
        end
    end

    nshp_walker u_walker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (walk_result)
    );

    nshp_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step && r_in_last),
        .i_result (walk_result),
        .o_space  (out_space),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_long_enough = out_result.long_enough;
    assign o_magic_valid = out_result.magic_valid;
    assign o_load_addr   = out_result.load_addr;
    assign o_init_addr   = out_result.init_addr;
    assign o_play_addr   = out_result.play_addr;
    assign o_num_songs   = out_result.num_songs;

endmodule

`default_nettype wire

// ===== tb/nsfe_chunk_header_parser_top_test.sv =====
// Self-checking testbench for the NSFE chunk header parser, with its own chunk walker as predictor.
`timescale 1ns / 100ps

module nsfe_chunk_header_parser_top_test;
    import nshp_pkg::*;

    // "NSFE" as it arrives on the wire, first byte in the low bits.
    localparam logic [31:0] NSFE_MAGIC_LE   = 32'h4546_534E;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES    = 10;
    localparam int unsigned MAX_REPORTS     = 10;
    localparam int unsigned PHASE_BYTES     = 420;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_file_word;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_file_byte = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_long_enough;
    logic        o_magic_valid;
    logic [15:0] o_load_addr;
    logic [15:0] o_init_addr;
    logic [15:0] o_play_addr;
    logic [7:0]  o_num_songs;

    nsfe_chunk_header_parser_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_file_byte   (i_file_byte),
        .i_last_byte   (i_last_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_long_enough (o_long_enough),
        .o_magic_valid (o_magic_valid),
        .o_load_addr   (o_load_addr),
        .o_init_addr   (o_init_addr),
        .o_play_addr   (o_play_addr),
        .o_num_songs   (o_num_songs)
    );

    // Stimulus and scoreboard storage.
    t_file_word  byte_fifo[$];
    logic [7:0]  file_buf[$];
    t_result     expected_results[$];
    t_file_word  next_word;
    logic        word_taken   = 1'b0;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    logic        hold_request = 1'b0;
    int unsigned hold_left    = 0;

    int unsigned mismatches     = 0;
    int unsigned results_seen   = 0;
    int unsigned bytes_accepted = 0;
    int unsigned files_queued   = 0;
    int unsigned phase_bytes    = 0;
    int unsigned phase_files    = 0;
    int unsigned short_files    = 0;
    int unsigned bad_magic_seen = 0;
    int unsigned info_taken     = 0;
    int unsigned nend_taken     = 0;

    // Predictor state of the chunk walker.
    logic [3:0]  seen_count;
    t_phase      walk_phase;
    logic [2:0]  hdr_pos;
    logic [63:0] hdr_bytes;
    logic [31:0] skip_left;
    logic        in_info;
    logic [3:0]  info_pos;
    logic        magic_ok;
    logic [15:0] cap_load;
    logic [15:0] cap_init;
    logic [15:0] cap_play;
    logic [7:0]  cap_songs;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3ms;
        $display("Timeout with %0d results still awaited", expected_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic reset_walker();
        seen_count = '0;
        walk_phase = PH_MAGIC;
        hdr_pos    = '0;
        hdr_bytes  = '0;
        skip_left  = '0;
        in_info    = 1'b0;
        info_pos   = '0;
        magic_ok   = 1'b0;
        cap_load   = '0;
        cap_init   = '0;
        cap_play   = '0;
        cap_songs  = '0;
    endtask

    // Advances the walker by one accepted byte and queues the result on the last byte.
    task automatic take_byte(input logic [7:0] b, input logic last);
        t_result     res;
        logic [31:0] len;
        logic [31:0] id;
        if (seen_count < MIN_FILE_LEN) seen_count++;
        case (walk_phase)
            PH_MAGIC: begin
                if (hdr_pos == 3'd0) magic_ok = 1'b1;
                if (b != NSFE_MAGIC_LE[8 * hdr_pos[1:0] +: 8]) magic_ok = 1'b0;
                hdr_pos++;
                if (hdr_pos >= 3'd4) begin
                    hdr_pos    = '0;
                    hdr_bytes  = '0;
                    walk_phase = magic_ok ? PH_HEADER : PH_DONE;
                end
            end
            PH_HEADER: begin
                hdr_bytes |= 64'(b) << (8 * hdr_pos);
                if (hdr_pos >= 3'd7) begin
                    // A complete header only counts if the file goes on past it.
                    if (!last) begin
                        len       = hdr_bytes[31:0];
                        id        = hdr_bytes[63:32];
                        hdr_pos   = '0;
                        hdr_bytes = '0;
                        in_info   = 1'b0;
                        info_pos  = '0;
                        if (id == ID_INFO && len >= INFO_MIN_LEN) begin
                            in_info   = 1'b1;
                            cap_load  = '0;
                            cap_init  = '0;
                            cap_play  = '0;
                            cap_songs = '0;
                            info_taken++;
                        end
                        if (id == ID_NEND) begin
                            walk_phase = PH_DONE;
                            nend_taken++;
                        end else begin
                            skip_left  = len;
                            walk_phase = (len == 0) ? PH_HEADER : PH_PAYLOAD;
                        end
                    end
                end else begin
                    hdr_pos++;
                end
            end
            PH_PAYLOAD: begin
                if (skip_left == 0) begin
                    walk_phase = PH_HEADER;
                    hdr_pos    = '0;
                end else begin
                    if (in_info) begin
                        case (info_pos)
                            POS_LOAD_LO: cap_load[7:0]  = b;
                            POS_LOAD_HI: cap_load[15:8] = b;
                            POS_INIT_LO: cap_init[7:0]  = b;
                            POS_INIT_HI: cap_init[15:8] = b;
                            POS_PLAY_LO: cap_play[7:0]  = b;
                            POS_PLAY_HI: cap_play[15:8] = b;
                            POS_SONGS:   cap_songs      = b;
                            default: ;
                        endcase
                        if (info_pos < 4'd15) info_pos++;
                    end
                    skip_left--;
                    if (skip_left == 0) begin
                        in_info    = 1'b0;
                        info_pos   = '0;
                        hdr_pos    = '0;
                        walk_phase = PH_HEADER;
                    end
                end
            end
            default: ;
        endcase

        if (last) begin
            res.long_enough = (seen_count >= MIN_FILE_LEN);
            res.magic_valid = res.long_enough && magic_ok;
            res.load_addr   = res.long_enough ? cap_load : 16'h0000;
            res.init_addr   = res.long_enough ? cap_init : 16'h0000;
            res.play_addr   = res.long_enough ? cap_play : 16'h0000;
            res.num_songs   = res.long_enough ? cap_songs : 8'h00;
            expected_results.push_back(res);
            if (!res.long_enough) short_files++;
            else if (!magic_ok) bad_magic_seen++;
            reset_walker();
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: result %0d, %s: expected %h, got %h",
                         $time, results_seen, name, want, got);
        end
    endtask

    task automatic check_result();
        t_result want;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: result delivered with no file outstanding", $time);
        end else begin
            want = expected_results.pop_front();
            compare_field("long_enough", 16'(want.long_enough), 16'(o_long_enough));
            compare_field("magic_valid", 16'(want.magic_valid), 16'(o_magic_valid));
            compare_field("load_addr", want.load_addr, o_load_addr);
            compare_field("init_addr", want.init_addr, o_init_addr);
            compare_field("play_addr", want.play_addr, o_play_addr);
            compare_field("num_songs", 16'(want.num_songs), 16'(o_num_songs));
        end
        results_seen++;
    endtask

    // Monitor: results are checked before the byte of the same edge is predicted.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) check_result();
            if (i_in_valid && o_in_ready) begin
                word_taken = 1'b1;
                take_byte(i_file_byte, i_last_byte);
                bytes_accepted++;
            end
        end
    end

    // Driver: a word stays on the port until the edge that takes it.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || word_taken)) begin
            if (byte_fifo.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                next_word = byte_fifo.pop_front();
                i_file_byte <= next_word.data;
                i_last_byte <= next_word.last;
                i_in_valid  <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        word_taken = 1'b0;
    end

    // Receiver: random back-pressure, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic push_le32(input logic [31:0] v);
        for (int k = 0; k < 4; k++) file_buf.push_back(v[8 * k +: 8]);
    endtask

    task automatic queue_file();
        t_file_word w;
        foreach (file_buf[k]) begin
            w.data = file_buf[k];
            w.last = (k == file_buf.size() - 1);
            byte_fifo.push_back(w);
        end
        files_queued++;
        phase_files++;
        phase_bytes += file_buf.size();
    endtask

    // Mostly well-formed files with random chunks; the rest are broken or plain noise.
    task automatic build_random_file();
        int unsigned kind;
        int unsigned n_chunks;
        int unsigned len;
        int unsigned body;
        int unsigned pick;
        int unsigned keep;
        logic [31:0] id;
        logic [31:0] len_field;
        file_buf.delete();
        kind = $urandom_range(99);
        if (kind >= 85) begin
            body = $urandom_range(1, 40);
            for (int k = 0; k < body; k++) file_buf.push_back(8'($urandom));
            if ($urandom_range(1) == 1) file_buf[0] = NSFE_MAGIC_LE[7:0];
            return;
        end
        push_le32(NSFE_MAGIC_LE);
        n_chunks = $urandom_range(0, 4);
        for (int c = 0; c < n_chunks; c++) begin
            pick = $urandom_range(9);
            if (pick < 4) id = ID_INFO;
            else if (pick < 5) id = ID_NEND;
            else if (pick < 7) id = ID_INFO ^ (32'h1 << $urandom_range(31));
            else id = $urandom;
            if (id == ID_INFO && $urandom_range(4) != 0) len = $urandom_range(INFO_MIN_LEN, 14);
            else len = $urandom_range(0, 8);
            len_field = len;
            // Now and then a huge length, so that the file ends inside the payload.
            if ($urandom_range(29) == 0)
                len_field = ($urandom_range(1) == 1) ? 32'hFFFF_FFFF : {1'b1, 31'($urandom)};
            push_le32(len_field);
            push_le32(id);
            body = (len_field == len) ? len : $urandom_range(0, 12);
            for (int k = 0; k < body; k++) file_buf.push_back(8'($urandom));
            if (len_field != len) break;
        end
        for (int k = $urandom_range(0, 3); k > 0; k--) file_buf.push_back(8'($urandom));

        if (kind < 10) begin
            file_buf[$urandom_range(3)] ^= 8'($urandom_range(1, 255));
        end else if (kind < 35) begin
            keep = (kind < 20) ? $urandom_range(1, 7) : $urandom_range(1, file_buf.size());
            while (file_buf.size() > keep) void'(file_buf.pop_back());
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (byte_fifo.size() != 0 || i_in_valid || expected_results.size() != 0);
    endtask

    task automatic run_phase(input int unsigned tx_idle, input int unsigned rx_stall);
        tx_idle_pct  = tx_idle;
        rx_stall_pct = rx_stall;
        phase_bytes  = 0;
        phase_files  = 0;
        while (phase_bytes < PHASE_BYTES || phase_files < 12) begin
            build_random_file();
            queue_file();
        end
        // The sender then waits for every outstanding result before the next phase.
        wait_drained();
    endtask

    initial begin
        reset_walker();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A single all-ones byte, then an INFO chunk of minimum length followed by a
        // header that the end of the file cuts short.
        file_buf = '{8'hFF};
        queue_file();
        file_buf = '{8'h4E, 8'h53, 8'h46, 8'h45,
                     8'h09, 8'h00, 8'h00, 8'h00, 8'h49, 8'h4E, 8'h46, 8'h4F,
                     8'hFF, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h80, 8'hAA, 8'h55, 8'hFF,
                     8'h00, 8'h00, 8'h00};
        queue_file();
        wait_drained();

        run_phase(0, 0);
        run_phase(87, 0);
        run_phase(0, 87);
        run_phase(13, 13);

        // Tiny files against a receiver that holds off: the result stage fills and the
        // input has to stall.
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_request = 1'b1;
        @(posedge i_clk);
        for (int f = 0; f < 30; f++) begin
            file_buf.delete();
            repeat ($urandom_range(1, 3)) file_buf.push_back(8'($urandom));
            queue_file();
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d files (%0d bytes) under four idling mixes and one long output hold-off.",
                 files_queued, bytes_accepted);
        $display("Checked %0d results: %0d short, %0d bad magic, %0d INFO and %0d NEND chunks used.",
                 results_seen, short_files, bad_magic_seen, info_taken, nend_taken);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d results never delivered",
                     mismatches, expected_results.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== nsfe_chunk_header_parser_top.f =====
sv/nshp_pkg.sv
sv/nshp_walker.sv
sv/nshp_out_stage.sv
sv/nsfe_chunk_header_parser_top.sv
tb/nsfe_chunk_header_parser_top_test.sv
